FILE: sv/rule_mask_transition_pixel_assert.svh
// ----------------------------------------------------------------------------
// Rule mask transition assertion macros
// Shared concurrent check forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef RULE_MASK_TRANSITION_PIXEL_ASSERT_SVH
`define RULE_MASK_TRANSITION_PIXEL_ASSERT_SVH

// same-cycle implication
`define RMTP_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define RMTP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: sv/rmtp_pkg.sv
// ----------------------------------------------------------------------------
// Rule mask transition package
// Shared types and constants for the pixel lanes and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package rmtp_pkg;

	localparam int unsigned NumLanes = 4;
	localparam int unsigned ChW      = 8;
	localparam int unsigned StepW    = 9;
	localparam int unsigned SumW     = 2 * ChW;

	localparam logic [ChW-1:0] ChMax = 8'hFF;

	typedef enum logic {
		REQ_HARD = 1'b0,
		REQ_SOFT = 1'b1
	} req_type_t;

	typedef enum logic [1:0] {
		SEL_OLD   = 2'd0,
		SEL_NEW   = 2'd1,
		SEL_BLEND = 2'd2
	} pix_sel_t;

	typedef struct packed {
		pix_sel_t         sel;
		logic [ChW-1:0]   alpha;
	} lane_ctl_t;

endpackage

`default_nettype wire

FILE: sv/rule_mask_transition_pixel.sv
// ----------------------------------------------------------------------------
// Rule mask transition pixel unit
// Hard wipe or soft fade of one four-channel pixel against its rule byte.
//
//   channel | handshake            | payload
//   in      | in_valid / in_ready   | req_type, frame_step, mask_value,
//           |                      | new_ch0..3, old_ch0..3
//   out     | out_valid / out_ready | out_ch0..3, mask_out, pixel_touched
//
// One item per clock unless stalled, through three register stages
// (decode, multiply-add, divide and select); an accepted item passes through
// them in that order, and out_valid is the valid bit of the last stage.
// The whole pipeline advances together; it stalls only while the output
// register holds an item that out_ready has not taken.
// Reset clears the stage valid bits; the data registers are not reset.
// ----------------------------------------------------------------------------
`default_nettype none

`include "rule_mask_transition_pixel_assert.svh"

module rule_mask_transition_pixel
	import rmtp_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire logic             req_type,
	input  wire logic [StepW-1:0] frame_step,
	input  wire logic [ChW-1:0]   mask_value,
	input  wire logic [ChW-1:0]   new_ch0,
	input  wire logic [ChW-1:0]   new_ch1,
	input  wire logic [ChW-1:0]   new_ch2,
	input  wire logic [ChW-1:0]   new_ch3,
	input  wire logic [ChW-1:0]   old_ch0,
	input  wire logic [ChW-1:0]   old_ch1,
	input  wire logic [ChW-1:0]   old_ch2,
	input  wire logic [ChW-1:0]   old_ch3,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output logic      [ChW-1:0]   out_ch0,
	output logic      [ChW-1:0]   out_ch1,
	output logic      [ChW-1:0]   out_ch2,
	output logic      [ChW-1:0]   out_ch3,
	output logic      [ChW-1:0]   mask_out,
	output logic                  pixel_touched
);

	logic             en;
	logic             v_s1, v_s2, v_s3;
	logic [StepW-1:0] diff;
	logic             touched;
	lane_ctl_t        ctl_d;
	logic [ChW-1:0]   mask_d;
	lane_ctl_t        ctl_s1;
	logic [ChW-1:0]   mask_s1, mask_s2, mask_s3;
	logic             touched_s1, touched_s2, touched_s3;
	logic [ChW-1:0]   new_s1 [NumLanes];
	logic [ChW-1:0]   old_s1 [NumLanes];
	logic [ChW-1:0]   new_in [NumLanes];
	logic [ChW-1:0]   old_in [NumLanes];
	logic [ChW-1:0]   res_s3 [NumLanes];

	assign en       = !v_s3 || out_ready;
	assign in_ready = en;

	assign new_in[0] = new_ch0;
	assign new_in[1] = new_ch1;
	assign new_in[2] = new_ch2;
	assign new_in[3] = new_ch3;
	assign old_in[0] = old_ch0;
	assign old_in[1] = old_ch1;
	assign old_in[2] = old_ch2;
	assign old_in[3] = old_ch3;

	// decode: compare, alpha and the new rule byte
	always_comb begin
		touched   = {1'b0, mask_value} <= frame_step;
		diff      = frame_step - {1'b0, mask_value};
		ctl_d.sel = SEL_OLD;
		ctl_d.alpha = diff[StepW-1] ? ChMax : diff[ChW-1:0];
		mask_d    = mask_value;
		if (touched) begin
			unique case (req_type_t'(req_type))
				REQ_HARD: begin
					ctl_d.sel = SEL_NEW;
					mask_d    = ChMax;
				end
				REQ_SOFT: begin
					ctl_d.sel = SEL_BLEND;
					// clear once the blend has run past full strength
					if (({1'b0, mask_value} + {1'b0, ChMax}) < {1'b0, frame_step}) begin
						mask_d = '0;
					end
				end
				default: ctl_d.sel = SEL_OLD;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctl_s1     <= ctl_d;
			mask_s1    <= mask_d;
			touched_s1 <= touched;
			mask_s2    <= mask_s1;
			touched_s2 <= touched_s1;
			mask_s3    <= mask_s2;
			touched_s3 <= touched_s2;
			for (int i = 0; i < NumLanes; i++) begin
				new_s1[i] <= new_in[i];
				old_s1[i] <= old_in[i];
			end
		end
	end

	for (genvar g = 0; g < NumLanes; g++) begin : g_lane
		rmtp_lane u_lane (
			.clk    (clk),
			.en     (en),
			.ctl_s1 (ctl_s1),
			.new_s1 (new_s1[g]),
			.old_s1 (old_s1[g]),
			.res_s3 (res_s3[g])
		);
	end

	// merge lane results with the per-pixel fields
	assign out_valid     = v_s3;
	assign out_ch0       = res_s3[0];
	assign out_ch1       = res_s3[1];
	assign out_ch2       = res_s3[2];
	assign out_ch3       = res_s3[3];
	assign mask_out      = mask_s3;
	assign pixel_touched = touched_s3;

	`RMTP_ASSERT_NOW(a_ready_follows_out, 1'b1, in_ready == (!v_s3 || out_ready), "in_ready mismatch")
	`RMTP_ASSERT_NEXT(a_stall_holds_s2, v_s2 && !en, v_s2, "stage 2 item lost in stall")
	`RMTP_ASSERT_NEXT(a_accept_enters, in_valid && in_ready, v_s1, "accepted item not in stage 1")
	`RMTP_ASSERT_NOW(a_untouched_keeps_mask, v_s1 && !touched_s1 && en, ctl_s1.sel == SEL_OLD,
		"untouched pixel not passed through")

endmodule

`default_nettype wire

FILE: sv/rmtp_lane.sv
// ----------------------------------------------------------------------------
// Rule mask transition channel lane
// Blends one channel: weighted sum in the first stage, divide by 255 and
// select in the second.
// ----------------------------------------------------------------------------
`default_nettype none

module rmtp_lane
	import rmtp_pkg::*;
(
	input  wire logic           clk,
	input  wire logic           en,
	input  wire lane_ctl_t      ctl_s1,
	input  wire logic [ChW-1:0] new_s1,
	input  wire logic [ChW-1:0] old_s1,
	output logic      [ChW-1:0] res_s3
);

	logic [SumW-1:0] prod_new;
	logic [SumW-1:0] prod_old;
	logic [SumW-1:0] sum_s2;
	pix_sel_t        sel_s2;
	logic [ChW-1:0]  new_s2;
	logic [ChW-1:0]  old_s2;
	logic [SumW:0]   quo_acc;
	logic [ChW-1:0]  quo;
	logic [ChW-1:0]  res_d;

	// the two weights add to 255, so the sum never exceeds 255*255
	assign prod_new = new_s1 * ctl_s1.alpha;
	assign prod_old = old_s1 * (ChMax - ctl_s1.alpha);

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s2 <= prod_new + prod_old;
			sel_s2 <= ctl_s1.sel;
			new_s2 <= new_s1;
			old_s2 <= old_s1;
		end
	end

	// exact floor(x/255) for any x up to 255*255
	assign quo_acc = {1'b0, sum_s2} + {{(ChW+1){1'b0}}, sum_s2[SumW-1:ChW]}
		+ {{SumW{1'b0}}, 1'b1};
	assign quo = quo_acc[SumW-1:ChW];

	always_comb begin
		case (sel_s2)
			SEL_NEW:   res_d = new_s2;
			SEL_BLEND: res_d = quo;
			default:   res_d = old_s2;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_s3 <= res_d;
		end
	end

endmodule

`default_nettype wire

FILE: tb/rule_mask_transition_pixel_tb.sv
// ----------------------------------------------------------------------------
// Rule mask transition pixel testbench
// Streams hard-wipe and soft-fade pixels through the block under bursty input
// and a stalling output, predicts every result in-line and checks each output
// item field by field, in order.
// ----------------------------------------------------------------------------
`default_nettype none

module rule_mask_transition_pixel_tb;
	import rmtp_pkg::*;

	localparam int unsigned RandomItems = 1200;
	localparam int unsigned LimitCycles = 200000;
	localparam int unsigned DrainCycles = 12;
	localparam int unsigned HoldOffLen  = 150;
	localparam int unsigned FullAlpha   = 255;

	typedef struct packed {
		req_type_t                     req;
		logic [StepW-1:0]              step;
		logic [ChW-1:0]                mask;
		logic [NumLanes-1:0][ChW-1:0]  nw;
		logic [NumLanes-1:0][ChW-1:0]  od;
	} pix_item_t;

	typedef struct packed {
		logic [NumLanes-1:0][ChW-1:0]  ch;
		logic [ChW-1:0]                mask;
		logic                          touched;
	} pix_result_t;

	typedef enum logic [1:0] {
		RX_ALWAYS   = 2'd0,
		RX_RANDOM   = 2'd1,
		RX_SPARSE   = 2'd2,
		RX_PERIODIC = 2'd3
	} rx_mode_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [ChW-1:0] out_ch0, out_ch1, out_ch2, out_ch3, mask_out;
	logic pixel_touched;

	pix_item_t cur_pix = '0;
	logic req_type;
	logic [StepW-1:0] frame_step;
	logic [ChW-1:0] mask_value;
	logic [ChW-1:0] new_ch0, new_ch1, new_ch2, new_ch3;
	logic [ChW-1:0] old_ch0, old_ch1, old_ch2, old_ch3;

	pix_item_t   pixel_feed_q[$];
	pix_result_t expected_pixel_q[$];
	int unsigned mismatch_cnt = 0;
	logic        in_taken = 1'b0;
	int unsigned stall_left = 0;
	int unsigned cycle_cnt = 0;

	assign req_type   = cur_pix.req;
	assign frame_step = cur_pix.step;
	assign mask_value = cur_pix.mask;
	assign new_ch0    = cur_pix.nw[0];
	assign new_ch1    = cur_pix.nw[1];
	assign new_ch2    = cur_pix.nw[2];
	assign new_ch3    = cur_pix.nw[3];
	assign old_ch0    = cur_pix.od[0];
	assign old_ch1    = cur_pix.od[1];
	assign old_ch2    = cur_pix.od[2];
	assign old_ch3    = cur_pix.od[3];

	rule_mask_transition_pixel dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.req_type(req_type),
		.frame_step(frame_step),
		.mask_value(mask_value),
		.new_ch0(new_ch0),
		.new_ch1(new_ch1),
		.new_ch2(new_ch2),
		.new_ch3(new_ch3),
		.old_ch0(old_ch0),
		.old_ch1(old_ch1),
		.old_ch2(old_ch2),
		.old_ch3(old_ch3),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_ch0(out_ch0),
		.out_ch1(out_ch1),
		.out_ch2(out_ch2),
		.out_ch3(out_ch3),
		.mask_out(mask_out),
		.pixel_touched(pixel_touched)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	initial begin
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
	end

	// Wipe or fade of one pixel against its rule byte.
	function automatic pix_result_t transition_pixel(pix_item_t p);
		pix_result_t r;
		int unsigned alpha;
		int unsigned acc;
		int i;
		r.ch      = p.od;
		r.mask    = p.mask;
		r.touched = 1'b0;
		if ({1'b0, p.mask} <= p.step) begin
			r.touched = 1'b1;
			if (p.req == REQ_HARD) begin
				r.ch   = p.nw;
				r.mask = ChMax;
			end else begin
				alpha = p.step - p.mask;
				if (alpha > FullAlpha)
					alpha = FullAlpha;
				for (i = 0; i < NumLanes; i++) begin
					acc = p.nw[i] * alpha + p.od[i] * (FullAlpha - alpha);
					r.ch[i] = ChW'(acc / FullAlpha);
				end
				// fade has run past full strength: retire the rule byte
				if (p.mask + FullAlpha < p.step)
					r.mask = '0;
			end
		end
		return r;
	endfunction

	task automatic add_pixel(req_type_t req, int unsigned step, int unsigned mask,
			logic [31:0] nw, logic [31:0] od);
		pix_item_t p;
		p.req  = req;
		p.step = step[StepW-1:0];
		p.mask = mask[ChW-1:0];
		p.nw   = nw;
		p.od   = od;
		pixel_feed_q = {pixel_feed_q, p};
	endtask

	function automatic logic [31:0] edge_channels();
		logic [31:0] v;
		int i;
		for (i = 0; i < NumLanes; i++) begin
			case ($urandom_range(0, 3))
				0: v[i*8 +: 8] = 8'h00;
				1: v[i*8 +: 8] = 8'hFF;
				2: v[i*8 +: 8] = 8'h01;
				default: v[i*8 +: 8] = 8'hFE;
			endcase
		end
		return v;
	endfunction

	// Random pixel, biased toward the compare and clear boundaries and extreme channel values.
	function automatic pix_item_t random_pixel();
		pix_item_t p;
		int m;
		int s;
		p.req  = req_type_t'($urandom_range(0, 1));
		p.step = StepW'($urandom_range(0, 511));
		p.mask = ChW'($urandom_range(0, 255));
		p.nw   = $urandom();
		p.od   = $urandom();
		case ($urandom_range(0, 9))
			3, 4, 5: begin
				m = int'(p.step) - 3 + int'($urandom_range(0, 6));
				if (m < 0)
					m = 0;
				if (m > 255)
					m = 255;
				p.mask = ChW'(m);
			end
			6, 7: begin
				p.req = REQ_SOFT;
				s = int'(p.mask) + 255 - 2 + int'($urandom_range(0, 4));
				if (s > 511)
					s = 511;
				p.step = StepW'(s);
			end
			8: begin
				p.nw = edge_channels();
				p.od = edge_channels();
			end
			9: begin
				p.req  = REQ_HARD;
				p.step = StepW'($urandom_range(256, 511));
			end
			default: ;
		endcase
		return p;
	endfunction

	task automatic report_mismatch(string msg);
		$display("ERROR @%0t: %s", $realtime, msg);
		mismatch_cnt++;
	endtask

	task automatic check_field(string name, logic [8:0] got, logic [8:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
	endtask

	// Sender: bursts of items with random gaps, now and then a long gapless run.
	int unsigned burst_left = 1;
	int unsigned gap_left = 0;
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_taken) begin
			if (gap_left > 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (pixel_feed_q.size() > 0) begin
				cur_pix  <= pixel_feed_q.pop_front();
				in_valid <= 1'b1;
				if (burst_left <= 1) begin
					if ($urandom_range(0, 7) == 0) begin
						burst_left = $urandom_range(64, 160);
						gap_left   = 0;
					end else begin
						burst_left = $urandom_range(1, 12);
						gap_left   = $urandom_range(1, 8);
					end
				end else begin
					burst_left--;
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver: its own stall pattern, switched to a random mode after each random-length window.
	rx_mode_t rx_mode = RX_ALWAYS;
	int unsigned rx_window = 0;
	int unsigned rx_tick = 0;
	always @(negedge clk) begin
		logic take;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (rx_window == 0) begin
				rx_mode   = rx_mode_t'($urandom_range(0, 3));
				rx_window = $urandom_range(16, 96);
			end
			rx_window--;
			rx_tick++;
			case (rx_mode)
				RX_ALWAYS:   take = 1'b1;
				RX_RANDOM:   take = 1'($urandom_range(0, 1));
				RX_SPARSE:   take = ($urandom_range(0, 3) == 0);
				default:     take = (rx_tick % 3 == 0);
			endcase
			out_ready <= take && (stall_left == 0);
		end
	end

	// Long output hold-off, twice in the run, while the sender keeps offering.
	int unsigned seen_in = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				seen_in++;
				if (seen_in == 300 || seen_in == 800)
					stall_left <= HoldOffLen;
			end
			if (stall_left > 0 && !(in_valid && in_ready && (seen_in == 300 || seen_in == 800)))
				stall_left <= stall_left - 1;
		end
	end

	// Predict on input acceptance, check on output acceptance.
	always @(posedge clk) begin
		pix_result_t want;
		in_taken <= in_valid && in_ready;
		if (arst_n) begin
			if (in_valid && in_ready)
				expected_pixel_q = {expected_pixel_q, transition_pixel(cur_pix)};
			if (out_valid && out_ready) begin
				if (expected_pixel_q.size() == 0) begin
					report_mismatch("output item with none expected");
				end else begin
					want = expected_pixel_q.pop_front();
					check_field("out_ch0", out_ch0, want.ch[0]);
					check_field("out_ch1", out_ch1, want.ch[1]);
					check_field("out_ch2", out_ch2, want.ch[2]);
					check_field("out_ch3", out_ch3, want.ch[3]);
					check_field("mask_out", mask_out, want.mask);
					check_field("pixel_touched", pixel_touched, want.touched);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > LimitCycles) begin
			$display("ERROR: timeout, %0d items still expected", expected_pixel_q.size());
			$display("rule_mask_transition_pixel_tb: FAIL");
			$finish;
		end
	end

	initial begin
		int unsigned k;
		// untouched pixels keep the old image in both modes
		add_pixel(REQ_HARD, 0, 1, 32'hFFFFFFFF, 32'h00000000);
		add_pixel(REQ_SOFT, 100, 255, 32'h12345678, 32'h9ABCDEF0);
		add_pixel(REQ_HARD, 254, 255, 32'h00000000, 32'hFFFFFFFF);
		// hard wipe at and past the rule byte, full 9-bit step
		add_pixel(REQ_HARD, 0, 0, 32'hFFFFFFFF, 32'h00000000);
		add_pixel(REQ_HARD, 255, 255, 32'h00FF00FF, 32'hFF00FF00);
		add_pixel(REQ_HARD, 256, 255, 32'hA5A5A5A5, 32'h5A5A5A5A);
		add_pixel(REQ_HARD, 511, 255, 32'h01020304, 32'hFEFDFCFB);
		add_pixel(REQ_HARD, 511, 0, 32'h00000000, 32'hFFFFFFFF);
		// soft fade: zero alpha, partial, full alpha
		add_pixel(REQ_SOFT, 0, 0, 32'hFFFFFFFF, 32'h00000000);
		add_pixel(REQ_SOFT, 255, 255, 32'hFFFFFFFF, 32'h00000000);
		add_pixel(REQ_SOFT, 128, 0, 32'hFFFFFFFF, 32'h00000000);
		add_pixel(REQ_SOFT, 200, 72, 32'h00FF80FF, 32'hFF007F00);
		add_pixel(REQ_SOFT, 254, 0, 32'hFFFFFFFF, 32'h00000000);
		add_pixel(REQ_SOFT, 255, 0, 32'h00000000, 32'hFFFFFFFF);
		add_pixel(REQ_SOFT, 1, 0, 32'hFFFFFFFF, 32'hFFFFFFFF);
		// soft fade around the rule-byte clear boundary
		add_pixel(REQ_SOFT, 510, 255, 32'hFFFFFFFF, 32'h00000000);
		add_pixel(REQ_SOFT, 511, 255, 32'hFFFFFFFF, 32'h00000000);
		add_pixel(REQ_SOFT, 255, 0, 32'h80808080, 32'h7F7F7F7F);
		add_pixel(REQ_SOFT, 256, 0, 32'h80808080, 32'h7F7F7F7F);
		add_pixel(REQ_SOFT, 511, 0, 32'hFFFFFFFF, 32'hFFFFFFFF);
		add_pixel(REQ_SOFT, 300, 44, 32'h00000000, 32'h00000000);
		add_pixel(REQ_SOFT, 300, 45, 32'hDEADBEEF, 32'hCAFEF00D);
		for (k = 0; k < RandomItems; k++)
			pixel_feed_q = {pixel_feed_q, random_pixel()};

		wait (arst_n);
		do
			@(negedge clk);
		while (pixel_feed_q.size() != 0 || in_valid || expected_pixel_q.size() != 0);
		repeat (DrainCycles) @(negedge clk);
		if (mismatch_cnt == 0)
			$display("rule_mask_transition_pixel_tb: PASS");
		else
			$display("rule_mask_transition_pixel_tb: FAIL");
		$finish;
	end

endmodule

`default_nettype wire
